// ===== src/ccrp_pkg.sv =====
// ccrp_pkg: shared types and constants of the read-patching cheat device
// depends on: nothing
package ccrp_pkg;

  // bus access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // set-up register map
  localparam logic [15:0] MODE_ADDR      = 16'h8000;
  localparam logic [15:0] SLOT_BASE_ADDR = 16'h8001;
  localparam logic [15:0] SLOT_LAST_ADDR = 16'h800C;
  localparam logic [7:0]  MODE_CLEAR     = 8'h71;
  localparam logic [7:0]  MODE_START     = 8'h00;
  localparam logic [7:0]  MODE_INVERT    = 8'hFF;
  localparam logic [7:0]  ADDR_HI_FORCE  = 8'h80;

  // reset values of the slot registers
  localparam logic [15:0] SLOT_ADDR_RST = 16'hFFFF;
  localparam logic [7:0]  SLOT_BYTE_RST = 8'hFF;

  // mode byte layout: no-check bit of slot i at 1+i, enable at 4+i
  localparam int unsigned NOCHECK_LSB = 1;
  localparam int unsigned ENABLE_LSB  = 4;

  // slot index taken from the set-up address offset
  localparam int unsigned SLOT_IDX_W = 2;

  // which register of a slot a set-up write targets
  typedef enum logic [1:0] {
    PART_ADDR_HI = 2'd0,
    PART_ADDR_LO = 2'd1,
    PART_COMPARE = 2'd2,
    PART_VALUE   = 2'd3
  } ccrp_part_e;

  // mode state shared between set-up registers and patch logic
  typedef struct packed {
    logic [7:0] mode_bits;
    logic       patching_on;
  } ccrp_mode_t;

endpackage

// ===== src/ccrp_if.sv =====
// ccrp_in_if / ccrp_out_if: valid/ready channels for bus accesses and results
// depends on: nothing
interface ccrp_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] addr;
  logic [7:0]  data;
  logic [7:0]  cart_data;

  modport source (output valid, kind, addr, data, cart_data, input ready);
  modport sink   (input valid, kind, addr, data, cart_data, output ready);
endinterface

interface ccrp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       patched;
  logic       active;

  modport source (output valid, read_data, patched, active, input ready);
  modport sink   (input valid, read_data, patched, active, output ready);
endinterface

// ===== src/ccrp_setup_regs.sv =====
// ccrp_setup_regs: code slots, mode byte and active flag, updated by set-up writes
// depends on: ccrp_pkg
module ccrp_setup_regs #(
  parameter int unsigned NUM_SLOTS = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [15:0]         addr_i,
  input  logic [7:0]          data_i,
  output logic [15:0]         slot_addr_o [NUM_SLOTS],
  output logic [7:0]          slot_cmp_o  [NUM_SLOTS],
  output logic [7:0]          slot_val_o  [NUM_SLOTS],
  output ccrp_pkg::ccrp_mode_t mode_o,
  output logic                active_next_o
);
  import ccrp_pkg::*;

  logic [15:0]           slot_addr_q [NUM_SLOTS];
  logic [7:0]            slot_cmp_q  [NUM_SLOTS];
  logic [7:0]            slot_val_q  [NUM_SLOTS];
  ccrp_mode_t            mode_q;
  logic [15:0]           offset;
  logic                  slot_range;
  logic                  mode_hit;
  logic [SLOT_IDX_W-1:0] slot_idx;
  ccrp_part_e            part;

  // address decode of the set-up window
  assign mode_hit   = (addr_i == MODE_ADDR);
  assign slot_range = (addr_i >= SLOT_BASE_ADDR) && (addr_i <= SLOT_LAST_ADDR);
  assign offset     = addr_i - SLOT_BASE_ADDR;
  assign slot_idx   = offset[SLOT_IDX_W+1:2];
  assign part       = ccrp_part_e'(offset[1:0]);

  // active flag after this item
  assign active_next_o = mode_q.patching_on |
                         (wr_en_i && mode_hit && (data_i == MODE_START));

  // mode byte and active flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else if (wr_en_i && mode_hit) begin
      if (data_i == MODE_START) begin
        mode_q.patching_on <= 1'b1;
      end else if (data_i == MODE_CLEAR) begin
        mode_q.mode_bits <= '0;
      end else begin
        mode_q.mode_bits <= data_i ^ MODE_INVERT;
      end
    end
  end

  // slot registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_addr_q[i] <= SLOT_ADDR_RST;
        slot_cmp_q[i]  <= SLOT_BYTE_RST;
        slot_val_q[i]  <= SLOT_BYTE_RST;
      end
    end else if (wr_en_i && slot_range) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_idx == SLOT_IDX_W'(i)) begin
          case (part)
            PART_ADDR_HI: slot_addr_q[i][15:8] <= data_i | ADDR_HI_FORCE;
            PART_ADDR_LO: slot_addr_q[i][7:0]  <= data_i;
            PART_COMPARE: slot_cmp_q[i]        <= data_i;
            PART_VALUE:   slot_val_q[i]        <= data_i;
            default:      slot_val_q[i]        <= slot_val_q[i];
          endcase
        end
      end
    end
  end

  assign slot_addr_o = slot_addr_q;
  assign slot_cmp_o  = slot_cmp_q;
  assign slot_val_o  = slot_val_q;
  assign mode_o      = mode_q;

endmodule

// ===== src/ccrp_patch_logic.sv =====
// ccrp_patch_logic: applies the enabled slots in order to a read
// depends on: ccrp_pkg
module ccrp_patch_logic #(
  parameter int unsigned NUM_SLOTS = 3
) (
  input  logic                 kind_i,
  input  logic [15:0]          addr_i,
  input  logic [7:0]           cart_data_i,
  input  logic [15:0]          slot_addr_i [NUM_SLOTS],
  input  logic [7:0]           slot_cmp_i  [NUM_SLOTS],
  input  logic [7:0]           slot_val_i  [NUM_SLOTS],
  input  ccrp_pkg::ccrp_mode_t mode_i,
  output logic [7:0]           read_data_o,
  output logic                 patched_o
);
  import ccrp_pkg::*;

  // slot chain, each slot sees the byte left by the one before
  always_comb begin
    logic [7:0] r;
    logic       hit;
    r   = cart_data_i;
    hit = 1'b0;
    if (mode_i.patching_on) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (mode_i.mode_bits[ENABLE_LSB + i] && (addr_i == slot_addr_i[i]) &&
            (mode_i.mode_bits[NOCHECK_LSB + i] || (r == slot_cmp_i[i]))) begin
          r   = slot_val_i[i];
          hit = 1'b1;
        end
      end
    end
    if (kind_i == KIND_WRITE) begin
      read_data_o = '0;
      patched_o   = 1'b0;
    end else begin
      read_data_o = r;
      patched_o   = hit;
    end
  end

endmodule

// ===== src/cheat_code_read_patcher_core.sv =====
// cheat_code_read_patcher_core: read-patching cheat device between cpu and cartridge
// depends on: ccrp_pkg, ccrp_if, ccrp_setup_regs, ccrp_patch_logic
// path: an access waits in the input register, then its result is loaded into the result register
// throughput: one access per cycle while results are taken, else the input register stalls;
// the input register and the result register each hold one item
// slots update as an item leaves the input register, so each access sees all earlier ones
// reset: slot addresses 0xFFFF, compare and value bytes 0xFF, mode byte 0, set-up phase
module cheat_code_read_patcher_core #(
  parameter int unsigned NUM_SLOTS = 3
) (
  input logic        clk_i,
  input logic        rst_ni,
  ccrp_in_if.sink    in_i,
  ccrp_out_if.source out_o
);
  import ccrp_pkg::*;

  logic        s1_valid_q;
  logic        s1_kind_q;
  logic [15:0] s1_addr_q;
  logic [7:0]  s1_data_q;
  logic [7:0]  s1_cart_q;
  logic        s1_adv;
  logic        in_acc;

  logic        out_valid_q;
  logic [7:0]  out_read_data_q;
  logic        out_patched_q;
  logic        out_active_q;

  logic [15:0] slot_addr [NUM_SLOTS];
  logic [7:0]  slot_cmp  [NUM_SLOTS];
  logic [7:0]  slot_val  [NUM_SLOTS];
  ccrp_mode_t  mode;
  logic        active_next;
  logic        wr_en;
  logic [7:0]  read_data_d;
  logic        patched_d;

  // handshake control
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;
  assign wr_en      = s1_adv && (s1_kind_q == KIND_WRITE) && !mode.patching_on;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q <= in_i.kind;
      s1_addr_q <= in_i.addr;
      s1_data_q <= in_i.data;
      s1_cart_q <= in_i.cart_data;
    end
  end

  ccrp_setup_regs #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_setup_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (wr_en),
    .addr_i        (s1_addr_q),
    .data_i        (s1_data_q),
    .slot_addr_o   (slot_addr),
    .slot_cmp_o    (slot_cmp),
    .slot_val_o    (slot_val),
    .mode_o        (mode),
    .active_next_o (active_next)
  );

  ccrp_patch_logic #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_patch_logic (
    .kind_i      (s1_kind_q),
    .addr_i      (s1_addr_q),
    .cart_data_i (s1_cart_q),
    .slot_addr_i (slot_addr),
    .slot_cmp_i  (slot_cmp),
    .slot_val_i  (slot_val),
    .mode_i      (mode),
    .read_data_o (read_data_d),
    .patched_o   (patched_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_read_data_q <= read_data_d;
      out_patched_q   <= patched_d;
      out_active_q    <= active_next;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_read_data_q;
  assign out_o.patched   = out_patched_q;
  assign out_o.active    = out_active_q;

endmodule
